>>> rtl/core/tkz_pkg.sv
// Shared types, character constants and helpers for the argument tokenizer.
package tkz_pkg;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic ROLE_KEY   = 1'b0;
  localparam logic ROLE_VALUE = 1'b1;

  typedef enum logic [6:0] {
    MODE_PREFIX = 7'b0000001,
    MODE_SKIP   = 7'b0000010,
    MODE_KEY    = 7'b0000100,
    MODE_QKEY   = 7'b0001000,
    MODE_EQ     = 7'b0010000,
    MODE_VALUE  = 7'b0100000,
    MODE_QVALUE = 7'b1000000
  } tkz_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } tkz_item_t;

  typedef struct packed {
    logic       char_valid;
    logic       char_role;
    logic [7:0] out_char;
    logic       pair_end;
    logic       line_done;
    logic       unterminated;
  } tkz_result_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

endpackage

>>> rtl/core/tkz_if.sv
// Valid/ready channel interfaces for the character and result words.
interface tkz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface tkz_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic       char_role;
  logic [7:0] out_char;
  logic       pair_end;
  logic       line_done;
  logic       unterminated;

  modport source (output valid, output char_valid, output char_role, output out_char,
                  output pair_end, output line_done, output unterminated, input ready);
  modport sink (input valid, input char_valid, input char_role, input out_char,
                input pair_end, input line_done, input unterminated, output ready);
endinterface

>>> rtl/core/tkz_in_stage.sv
// Input register that captures one character word per cycle while it is empty or being drained.
module tkz_in_stage import tkz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      src_valid,
  output logic      src_ready,
  input  tkz_item_t src_item,
  input  logic      take,
  output logic      item_vld,
  output tkz_item_t item
);

  logic      vld_r;
  logic      vld_nxt;
  tkz_item_t item_r;
  logic      load;

  assign src_ready = !vld_r || take;
  assign load      = src_valid && src_ready;
  assign vld_nxt   = load ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= src_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> rtl/core/tkz_parse.sv
// Scan state machine that classifies each character and tracks quotes and prefix.
module tkz_parse import tkz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        take,
  input  tkz_item_t   item,
  output tkz_result_t result
);

  logic [7:0] prefix_length_r;
  tkz_mode_t  mode_r;
  tkz_mode_t  mode_nxt;
  logic [7:0] prefix_count_r;
  logic [7:0] prefix_count_nxt;
  logic [7:0] prev_char_r;
  logic [7:0] prev_char_nxt;
  tkz_mode_t  eff_mode;
  logic       sp;

  assign sp = is_space(item.ch);

  always_comb begin
    eff_mode = mode_r;
    if ((mode_r == MODE_PREFIX) && (prefix_count_r >= prefix_length_r)) begin
      eff_mode = MODE_SKIP;
    end
  end

  always_comb begin
    mode_nxt         = eff_mode;
    prefix_count_nxt = prefix_count_r;
    prev_char_nxt    = prev_char_r;
    result           = '0;
    if (item.line_end) begin
      result.line_done = 1'b1;
      result.pair_end  = (eff_mode == MODE_KEY) || (eff_mode == MODE_EQ) ||
                         (eff_mode == MODE_VALUE);
      result.unterminated = (eff_mode == MODE_QKEY) || (eff_mode == MODE_QVALUE);
      mode_nxt         = MODE_PREFIX;
      prefix_count_nxt = '0;
      prev_char_nxt    = CH_QUOTE;
    end else begin
      case (eff_mode)
        MODE_PREFIX: begin
          prefix_count_nxt = prefix_count_r + 8'd1;
        end
        MODE_SKIP: begin
          if (sp) begin
            mode_nxt = MODE_SKIP;
          end else if (item.ch == CH_QUOTE) begin
            mode_nxt      = MODE_QKEY;
            prev_char_nxt = CH_QUOTE;
          end else if (item.ch == CH_EQ) begin
            mode_nxt = MODE_EQ;
          end else begin
            mode_nxt          = MODE_KEY;
            result.char_valid = 1'b1;
            result.char_role  = ROLE_KEY;
            result.out_char   = item.ch;
          end
        end
        MODE_KEY: begin
          if (item.ch == CH_EQ) begin
            mode_nxt = MODE_EQ;
          end else if (sp) begin
            result.pair_end = 1'b1;
            mode_nxt        = MODE_SKIP;
          end else begin
            result.char_valid = 1'b1;
            result.char_role  = ROLE_KEY;
            result.out_char   = item.ch;
          end
        end
        MODE_EQ: begin
          if (item.ch == CH_QUOTE) begin
            mode_nxt      = MODE_QVALUE;
            prev_char_nxt = CH_QUOTE;
          end else if (sp) begin
            result.pair_end = 1'b1;
            mode_nxt        = MODE_SKIP;
          end else begin
            mode_nxt          = MODE_VALUE;
            result.char_valid = 1'b1;
            result.char_role  = ROLE_VALUE;
            result.out_char   = item.ch;
          end
        end
        MODE_VALUE: begin
          if (sp) begin
            result.pair_end = 1'b1;
            mode_nxt        = MODE_SKIP;
          end else begin
            result.char_valid = 1'b1;
            result.char_role  = ROLE_VALUE;
            result.out_char   = item.ch;
          end
        end
        MODE_QKEY, MODE_QVALUE: begin
          if ((item.ch == CH_QUOTE) && (prev_char_r != CH_BSLASH)) begin
            result.pair_end = 1'b1;
            mode_nxt        = MODE_SKIP;
          end else begin
            result.char_valid = 1'b1;
            result.char_role  = (eff_mode == MODE_QVALUE) ? ROLE_VALUE : ROLE_KEY;
            result.out_char   = item.ch;
            prev_char_nxt     = item.ch;
          end
        end
        default: begin
          mode_nxt = MODE_SKIP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_length_r <= '0;
      mode_r          <= MODE_PREFIX;
      prefix_count_r  <= '0;
      prev_char_r     <= CH_QUOTE;
    end else begin
      if (cfg_wr_en) begin
        prefix_length_r <= cfg_wr_data;
      end
      if (take) begin
        mode_r         <= mode_nxt;
        prefix_count_r <= prefix_count_nxt;
        prev_char_r    <= prev_char_nxt;
      end
    end
  end

  // Every end of line returns the scanner to the start-of-line state.
  assert property (@(posedge clk) disable iff (!rst_n)
    take && item.line_end |=> (mode_r == MODE_PREFIX) && (prefix_count_r == 8'd0) &&
      (prev_char_r == CH_QUOTE))
    else $error("scanner not restarted after end of line");

  // An open quote at end of line drops the pair instead of closing it.
  assert property (@(posedge clk) disable iff (!rst_n)
    take && result.unterminated |-> result.line_done && !result.pair_end)
    else $error("unterminated flag without line end or with pair end");

  // Text characters never come with an end of line.
  assert property (@(posedge clk) disable iff (!rst_n)
    take && result.char_valid |-> !result.line_done && !result.pair_end)
    else $error("text character reported together with an end mark");

  // The prefix counter only moves while the prefix is being skipped or at an end of line.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_PREFIX) |-> (prefix_count_r == $past(prefix_count_r)) ||
      $past(take && item.line_end))
    else $error("prefix counter moved outside the prefix");

endmodule

>>> rtl/core/tkz_out_stage.sv
// Result register that holds one result word until the sink takes it.
module tkz_out_stage import tkz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_vld,
  input  tkz_result_t result,
  output logic        take,
  output logic        dst_valid,
  input  logic        dst_ready,
  output tkz_result_t dst_result
);

  logic        vld_r;
  logic        vld_nxt;
  tkz_result_t res_r;

  assign take    = item_vld && (!vld_r || dst_ready);
  assign vld_nxt = take ? 1'b1 : (dst_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign dst_valid  = vld_r;
  assign dst_result = res_r;

endmodule

>>> rtl/core/key_value_argument_tokenizer.sv
// Top level of the key/value command-line argument tokenizer.
//
//   channel   direction  payload                                        handshake
//   in_chan   sink       ch[7:0], line_end                               valid/ready
//   out_chan  source     char_valid, char_role, out_char[7:0],           valid/ready
//                        pair_end, line_done, unterminated
//   cfg_*     write      cfg_wr_data[7:0] = prefix_length                cfg_wr_en
//
// Unless the output stalls, one word is accepted per cycle, its result word is registered,
// and the scan state machine decodes one character per cycle between the input and result
// registers. Reset is synchronous and active low; it clears the state and prefix_length.
// A stalled output holds its word; the input register still takes one more word.
module key_value_argument_tokenizer import tkz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tkz_in_if.sink     in_chan,
  tkz_out_if.source  out_chan,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  tkz_item_t   src_item;
  tkz_item_t   item;
  logic        item_vld;
  logic        take;
  tkz_result_t result;
  tkz_result_t dst_result;

  assign src_item.ch       = in_chan.ch;
  assign src_item.line_end = in_chan.line_end;

  tkz_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (in_chan.valid),
    .src_ready (in_chan.ready),
    .src_item  (src_item),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  tkz_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .item        (item),
    .result      (result)
  );

  tkz_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .result     (result),
    .take       (take),
    .dst_valid  (out_chan.valid),
    .dst_ready  (out_chan.ready),
    .dst_result (dst_result)
  );

  assign out_chan.char_valid   = dst_result.char_valid;
  assign out_chan.char_role    = dst_result.char_role;
  assign out_chan.out_char     = dst_result.out_char;
  assign out_chan.pair_end     = dst_result.pair_end;
  assign out_chan.line_done    = dst_result.line_done;
  assign out_chan.unterminated = dst_result.unterminated;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the key/value argument tokenizer with random handshakes.
`timescale 1ns / 1ps

module tb_top;
  import tkz_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 80;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  tkz_in_if  in_chan ();
  tkz_out_if out_chan ();

  key_value_argument_tokenizer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tkz_item_t   char_queue[$];
  tkz_item_t   line_buf[$];
  tkz_result_t predicted_words[$];

  tkz_mode_t  scan_state       = MODE_PREFIX;
  logic [7:0] skipped_count    = 8'd0;
  logic [7:0] last_quoted_char = CH_QUOTE;
  logic [7:0] prefix_setting   = 8'd0;

  int errors        = 0;
  int cycles        = 0;
  int words_queued  = 0;
  int words_in      = 0;
  int words_out     = 0;
  int lines_seen    = 0;
  int pairs_seen    = 0;
  int unterm_seen   = 0;
  int text_seen     = 0;
  int prefix_writes = 0;
  int in_gap        = 0;
  int out_stall     = 0;
  bit in_burst      = 1'b0;
  bit out_flowing   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  function automatic tkz_result_t scan_char(input tkz_item_t it);
    tkz_result_t r;
    r = '0;
    if (scan_state == MODE_PREFIX && skipped_count >= prefix_setting) begin
      scan_state = MODE_SKIP;
    end
    if (it.line_end) begin
      r.line_done    = 1'b1;
      r.pair_end     = (scan_state == MODE_KEY) || (scan_state == MODE_EQ) ||
                       (scan_state == MODE_VALUE);
      r.unterminated = (scan_state == MODE_QKEY) || (scan_state == MODE_QVALUE);
      scan_state       = MODE_PREFIX;
      skipped_count    = 8'd0;
      last_quoted_char = CH_QUOTE;
    end else begin
      case (scan_state)
        MODE_PREFIX: begin
          skipped_count = skipped_count + 8'd1;
        end
        MODE_SKIP: begin
          if (is_blank(it.ch)) begin
          end else if (it.ch == CH_QUOTE) begin
            scan_state       = MODE_QKEY;
            last_quoted_char = CH_QUOTE;
          end else if (it.ch == CH_EQ) begin
            scan_state = MODE_EQ;
          end else begin
            scan_state   = MODE_KEY;
            r.char_valid = 1'b1;
            r.char_role  = ROLE_KEY;
            r.out_char   = it.ch;
          end
        end
        MODE_KEY: begin
          if (it.ch == CH_EQ) begin
            scan_state = MODE_EQ;
          end else if (is_blank(it.ch)) begin
            r.pair_end = 1'b1;
            scan_state = MODE_SKIP;
          end else begin
            r.char_valid = 1'b1;
            r.char_role  = ROLE_KEY;
            r.out_char   = it.ch;
          end
        end
        MODE_EQ: begin
          if (it.ch == CH_QUOTE) begin
            scan_state       = MODE_QVALUE;
            last_quoted_char = CH_QUOTE;
          end else if (is_blank(it.ch)) begin
            r.pair_end = 1'b1;
            scan_state = MODE_SKIP;
          end else begin
            scan_state   = MODE_VALUE;
            r.char_valid = 1'b1;
            r.char_role  = ROLE_VALUE;
            r.out_char   = it.ch;
          end
        end
        MODE_VALUE: begin
          if (is_blank(it.ch)) begin
            r.pair_end = 1'b1;
            scan_state = MODE_SKIP;
          end else begin
            r.char_valid = 1'b1;
            r.char_role  = ROLE_VALUE;
            r.out_char   = it.ch;
          end
        end
        MODE_QKEY, MODE_QVALUE: begin
          if (it.ch == CH_QUOTE && last_quoted_char != CH_BSLASH) begin
            r.pair_end = 1'b1;
            scan_state = MODE_SKIP;
          end else begin
            r.char_valid     = 1'b1;
            r.char_role      = (scan_state == MODE_QVALUE) ? ROLE_VALUE : ROLE_KEY;
            r.out_char       = it.ch;
            last_quoted_char = it.ch;
          end
        end
        default: begin
          scan_state = MODE_SKIP;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tkz_item_t nxt;
    logic      held;
    if (!rst_n) begin
      in_chan.valid    <= 1'b0;
      in_chan.ch       <= 8'd0;
      in_chan.line_end <= 1'b0;
    end else begin
      held = in_chan.valid && !in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        predicted_words = {predicted_words, scan_char({in_chan.ch, in_chan.line_end})};
        words_in++;
        if ($urandom_range(0, 39) == 0) begin
          in_burst = !in_burst;
        end
        in_gap = in_burst ? 0 : int'($urandom_range(0, 12));
      end
      if (!held) begin
        if (in_gap != 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (char_queue.size() != 0) begin
          nxt = char_queue.pop_front();
          in_chan.valid    <= 1'b1;
          in_chan.ch       <= nxt.ch;
          in_chan.line_end <= nxt.line_end;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tkz_result_t got;
    tkz_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.char_valid, out_chan.char_role, out_chan.out_char,
               out_chan.pair_end, out_chan.line_done, out_chan.unterminated};
        if (predicted_words.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, got);
          errors++;
        end else begin
          want = predicted_words.pop_front();
          words_out++;
          if (got.char_valid !== want.char_valid || got.char_role !== want.char_role ||
              got.out_char !== want.out_char || got.pair_end !== want.pair_end ||
              got.line_done !== want.line_done ||
              got.unterminated !== want.unterminated) begin
            $display("%0t: mismatch expected %b %b %h %b %b %b, got %b %b %h %b %b %b",
                     $time, want.char_valid, want.char_role, want.out_char, want.pair_end,
                     want.line_done, want.unterminated, got.char_valid, got.char_role,
                     got.out_char, got.pair_end, got.line_done, got.unterminated);
            errors++;
          end
          if (want.char_valid) text_seen++;
          if (want.pair_end) pairs_seen++;
          if (want.line_done) lines_seen++;
          if (want.unterminated) unterm_seen++;
        end
        if ($urandom_range(0, 39) == 0) begin
          out_flowing = !out_flowing;
        end
        out_stall = out_flowing ? 0 : int'($urandom_range(0, 12));
      end
      if (out_stall != 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic put(input logic [7:0] c, input logic e);
    tkz_item_t it;
    it.ch       = c;
    it.line_end = e;
    line_buf    = {line_buf, it};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i], 1'b0);
    end
  endtask

  task automatic flush_line(input bit cut);
    int n;
    n = line_buf.size();
    if (cut) begin
      n = (n > 1) ? int'($urandom_range(1, n - 1)) : 0;
    end
    for (int i = 0; i < n; i++) begin
      char_queue = {char_queue, line_buf[i]};
    end
    words_queued += n;
    line_buf.delete();
  endtask

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] plain_byte(input bit allow_eq, input bit allow_quote);
    logic [7:0] c;
    do begin
      c = $urandom_range(0, 1) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
    end while (is_blank(c) || (!allow_eq && c == CH_EQ) || (!allow_quote && c == CH_QUOTE));
    return c;
  endfunction

  task automatic put_quoted(output bit open);
    logic [7:0] c;
    put(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 6))
        0: begin
          put(CH_BSLASH, 1'b0);
          put(CH_QUOTE, 1'b0);
        end
        1: put(blank_byte(), 1'b0);
        2: put(CH_EQ, 1'b0);
        default: begin
          do begin
            c = 8'($urandom_range(0, 255));
          end while (c == CH_QUOTE || c == CH_BSLASH);
          put(c, 1'b0);
        end
      endcase
    end
    open = ($urandom_range(0, 7) == 0);
    if (!open) begin
      put(CH_QUOTE, 1'b0);
    end
  endtask

  task automatic put_value(output bit open);
    open = 1'b0;
    put(CH_EQ, 1'b0);
    case ($urandom_range(0, 4))
      0: begin
      end
      1: put_quoted(open);
      default: begin
        repeat ($urandom_range(1, 5)) put(plain_byte(1'b1, 1'b1), 1'b0);
      end
    endcase
  endtask

  task automatic put_arg(output bit open);
    open = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        put(plain_byte(1'b0, 1'b0), 1'b0);
        repeat ($urandom_range(0, 4)) put(plain_byte(1'b0, 1'b1), 1'b0);
        if ($urandom_range(0, 2) != 0) begin
          put_value(open);
        end
      end
      4, 5: begin
        put_quoted(open);
      end
      6: begin
        put_value(open);
      end
      7: begin
        repeat ($urandom_range(1, 3)) put(plain_byte(1'b0, 1'b0), 1'b0);
        put(CH_EQ, 1'b0);
        put_quoted(open);
      end
      8: begin
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        put_quoted(open);
        if (!open) begin
          repeat ($urandom_range(1, 3)) put(plain_byte(1'b0, 1'b0), 1'b0);
        end
      end
    endcase
  endtask

  task automatic gen_line(input int pre, input bit cut);
    int  n;
    bit  open;
    int  args;
    n    = pre;
    open = 1'b0;
    if (pre > 0 && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(0, pre - 1);
    end
    repeat (n) put(8'($urandom_range(0, 255)), 1'b0);
    if (n == pre) begin
      args = $urandom_range(0, 4);
      for (int a = 0; a < args && !open; a++) begin
        repeat ($urandom_range((a == 0) ? 0 : 1, 2)) put(blank_byte(), 1'b0);
        put_arg(open);
      end
      if (!open) begin
        repeat ($urandom_range(0, 1)) put(blank_byte(), 1'b0);
      end
    end
    put(8'($urandom_range(0, 255)), 1'b1);
    flush_line(cut);
  endtask

  task automatic write_prefix(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    prefix_setting = v;
    prefix_writes++;
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (char_queue.size() != 0 || in_chan.valid || predicted_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int         start;
    logic [7:0] setting;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 8'd0;
    in_chan.valid    = 1'b0;
    in_chan.ch       = 8'd0;
    in_chan.line_end = 1'b0;
    out_chan.ready   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty key, quote inside a bare key, escaped quote left open at the end of the line.
    write_prefix(8'd0);
    put_text("=v a\"b=c \"q=\\\"");
    put(8'h00, 1'b1);
    flush_line(1'b0);
    // A closing quote runs straight into the next key; the line ends right after '='.
    put_text("\"x\"y=");
    put(8'hFF, 1'b1);
    flush_line(1'b0);
    // Extreme codes as key text, then an empty value closed by a tab.
    put(8'hFF, 1'b0);
    put(8'h00, 1'b0);
    put_text(" =\t");
    put(8'hAA, 1'b1);
    flush_line(1'b0);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = 8'd255;
        1: setting = 8'd0;
        2: setting = 8'd1;
        default: setting = 8'($urandom_range(0, 10));
      endcase
      write_prefix(setting);
      start = words_queued;
      while (words_queued - start < PHASE_WORDS) begin
        gen_line(setting, 1'b0);
      end
      if ($urandom_range(0, 1) != 0) begin
        gen_line(setting, 1'b1);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (predicted_words.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, predicted_words.size());
      errors++;
    end
    $display("Checked %0d of %0d words over %0d lines: %0d text chars, %0d pairs, %0d open quotes.",
             words_out, words_in, lines_seen, text_seen, pairs_seen, unterm_seen);
    $display("The prefix length was set %0d times, including 0 and 255; %0d errors.",
             prefix_writes, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tkz_pkg.sv
rtl/core/tkz_if.sv
rtl/core/tkz_in_stage.sv
rtl/core/tkz_parse.sv
rtl/core/tkz_out_stage.sv
rtl/core/key_value_argument_tokenizer.sv
bench/tb_top.sv
